/* hw/rtl/sus_pkg.sv */
// Package for the sorted unique set engine: widths, operation codes, status codes
// and the control types shared by the top level and the storage cells.
// No dependencies.
package sus_pkg;

    localparam int DATA_W           = 32;
    localparam int OP_W             = 2;
    localparam int STATUS_W         = 3;
    localparam int COUNT_OUT_W      = 6;
    localparam int CAPACITY_DEFAULT = 32;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_LIST   = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED      = 3'd0,
        ST_DUPLICATE     = 3'd1,
        ST_REMOVED       = 3'd2,
        ST_NOT_FOUND     = 3'd3,
        ST_EMPTY         = 3'd4,
        ST_FULL_OR_ENTRY = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_ROTATE
    } t_cell_op;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        t_cell_op                  op;
        logic signed [DATA_W-1:0]  value;
    } t_cell_ctrl;

    // Where a cell sits relative to the current fill level.
    typedef struct packed {
        logic occupied;
        logic tail;
    } t_cell_pos;

endpackage

/* hw/rtl/sus_req_if.sv */
// Request channel of the sorted unique set engine: valid/ready and one request item.
// Depends on sus_pkg.
interface sus_req_if;
    logic                              valid;
    logic                              ready;
    logic [sus_pkg::OP_W-1:0]          operation;
    logic signed [sus_pkg::DATA_W-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

/* hw/rtl/sus_rsp_if.sv */
// Result channel of the sorted unique set engine: valid/ready and one result item.
// Depends on sus_pkg.
interface sus_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [sus_pkg::STATUS_W-1:0]        status;
    logic signed [sus_pkg::DATA_W-1:0]   entry_value;
    logic [sus_pkg::COUNT_OUT_W-1:0]     entry_count;
    logic                                last;

    modport source (output valid, output status, output entry_value, output entry_count,
                    output last, input ready);
    modport sink   (input valid, input status, input entry_value, input entry_count,
                    input last, output ready);
endinterface

/* hw/rtl/sus_cell.sv */
// One storage cell of the sorted chain: holds one entry, compares it with the
// broadcast value and shifts toward either neighbor. Depends on sus_pkg.
module sus_cell (
    input  logic                              i_clk,
    input  sus_pkg::t_cell_ctrl               i_ctrl,
    input  sus_pkg::t_cell_pos                i_pos,
    input  logic                              i_prev_lt,
    input  logic signed [sus_pkg::DATA_W-1:0] i_prev_entry,
    input  logic signed [sus_pkg::DATA_W-1:0] i_next_entry,
    input  logic signed [sus_pkg::DATA_W-1:0] i_first_entry,
    output logic signed [sus_pkg::DATA_W-1:0] o_entry,
    output logic                              o_lt,
    output logic                              o_eq
);

    logic signed [sus_pkg::DATA_W-1:0] r_entry;
    logic signed [sus_pkg::DATA_W-1:0] n_entry;

    assign o_entry = r_entry;
    assign o_lt    = i_pos.occupied && (r_entry < i_ctrl.value);
    assign o_eq    = i_pos.occupied && (r_entry == i_ctrl.value);

    always_comb begin
        n_entry = r_entry;
        case (i_ctrl.op)
            sus_pkg::CELL_INSERT: begin
                // Cells below the insertion point keep their entry; the first cell
                // at or above it takes the new value, the rest move up by one.
                if (!o_lt) begin
                    n_entry = i_prev_lt ? i_ctrl.value : i_prev_entry;
                end
            end
            sus_pkg::CELL_REMOVE: begin
                if (!o_lt) begin
                    n_entry = i_next_entry;
                end
            end
            sus_pkg::CELL_ROTATE: begin
                // Listing rotates the occupied part so each entry in turn reaches cell 0.
                n_entry = i_pos.tail ? i_first_entry : i_next_entry;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

/* hw/rtl/sorted_unique_set_engine_unit.sv */
// Sorted unique set engine: keeps up to CAPACITY distinct signed 32-bit values in
// ascending order in a chain of cells that all compare against the request value at
// once. Insert and remove update the chain as they are taken; a list gives one
// result per stored entry (a single result when the set is empty), the entries
// coming out by rotating the chain through cell 0.
// A new request is taken once the last result of the previous one is registered
// and the result register is free. Every request but an unused code gives results;
// the final one has last set. Depends on sus_pkg, sus_req_if, sus_rsp_if, sus_cell.
module sorted_unique_set_engine_unit #(
    parameter int CAPACITY = sus_pkg::CAPACITY_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sus_req_if.sink    i_req,
    sus_rsp_if.source  o_rsp
);

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic {
        S_IDLE,
        S_LIST
    } t_state;

    t_state                            r_state, n_state;
    logic [CW-1:0]                     r_count, n_count;
    logic [CW-1:0]                     r_left, n_left;
    logic                              r_o_valid, n_o_valid;
    sus_pkg::t_status                  r_status, n_status;
    logic signed [sus_pkg::DATA_W-1:0] r_entry_value, n_entry_value;
    logic [sus_pkg::COUNT_OUT_W-1:0]   r_entry_count, n_entry_count;
    logic                              r_last, n_last;

    sus_pkg::t_cell_ctrl               w_ctrl;
    logic [CAPACITY-1:0]               w_lt;
    logic [CAPACITY-1:0]               w_eq;
    logic signed [sus_pkg::DATA_W-1:0] w_entry [CAPACITY];

    logic w_out_free;
    logic w_accept;
    logic w_found;
    logic w_full;

    assign w_out_free  = !r_o_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE) && w_out_free;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_found     = |w_eq;
    assign w_full      = (r_count == CW'(CAPACITY));

    assign o_rsp.valid       = r_o_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.entry_value = r_entry_value;
    assign o_rsp.entry_count = r_entry_count;
    assign o_rsp.last        = r_last;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            sus_pkg::t_cell_pos                w_pos;
            logic                              w_prev_lt;
            logic signed [sus_pkg::DATA_W-1:0] w_prev;
            logic signed [sus_pkg::DATA_W-1:0] w_next;

            assign w_pos.occupied = (CW'(gi) < r_count);
            assign w_pos.tail     = (CW'(gi + 1) == r_count);

            if (gi == 0) begin : g_head
                assign w_prev_lt = 1'b1;
                assign w_prev    = w_entry[0];
            end else begin : g_body
                assign w_prev_lt = w_lt[gi-1];
                assign w_prev    = w_entry[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_end
                assign w_next = w_entry[gi];
            end else begin : g_mid
                assign w_next = w_entry[gi+1];
            end

            sus_cell u_cell (
                .i_clk         (i_clk),
                .i_ctrl        (w_ctrl),
                .i_pos         (w_pos),
                .i_prev_lt     (w_prev_lt),
                .i_prev_entry  (w_prev),
                .i_next_entry  (w_next),
                .i_first_entry (w_entry[0]),
                .o_entry       (w_entry[gi]),
                .o_lt          (w_lt[gi]),
                .o_eq          (w_eq[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_left        = r_left;
        n_o_valid     = w_out_free ? 1'b0 : r_o_valid;
        n_status      = r_status;
        n_entry_value = r_entry_value;
        n_entry_count = r_entry_count;
        n_last        = r_last;
        w_ctrl.op     = sus_pkg::CELL_HOLD;
        w_ctrl.value  = i_req.value;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_req.operation)
                        sus_pkg::OP_INSERT: begin
                            if (w_found) begin
                                n_status = sus_pkg::ST_DUPLICATE;
                            end else if (w_full) begin
                                n_status = sus_pkg::ST_FULL_OR_ENTRY;
                            end else begin
                                n_status  = sus_pkg::ST_INSERTED;
                                w_ctrl.op = sus_pkg::CELL_INSERT;
                                n_count   = r_count + CW'(1);
                            end
                            n_o_valid = 1'b1;
                        end
                        sus_pkg::OP_REMOVE: begin
                            if (r_count == '0) begin
                                n_status = sus_pkg::ST_EMPTY;
                            end else if (w_found) begin
                                n_status  = sus_pkg::ST_REMOVED;
                                w_ctrl.op = sus_pkg::CELL_REMOVE;
                                n_count   = r_count - CW'(1);
                            end else begin
                                n_status = sus_pkg::ST_NOT_FOUND;
                            end
                            n_o_valid = 1'b1;
                        end
                        sus_pkg::OP_LIST: begin
                            if (r_count == '0) begin
                                n_status  = sus_pkg::ST_EMPTY;
                                n_o_valid = 1'b1;
                            end else begin
                                n_state = S_LIST;
                                n_left  = r_count;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                    n_entry_value = i_req.value;
                    n_entry_count = sus_pkg::COUNT_OUT_W'(n_count);
                    n_last        = 1'b1;
                end
            end
            S_LIST: begin
                if (w_out_free) begin
                    n_o_valid     = 1'b1;
                    n_status      = sus_pkg::ST_FULL_OR_ENTRY;
                    n_entry_value = w_entry[0];
                    n_entry_count = sus_pkg::COUNT_OUT_W'(r_count);
                    n_last        = (r_left == CW'(1));
                    w_ctrl.op     = sus_pkg::CELL_ROTATE;
                    n_left        = r_left - CW'(1);
                    if (r_left == CW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_left    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_left    <= n_left;
            r_o_valid <= n_o_valid;
        end
        r_status      <= n_status;
        r_entry_value <= n_entry_value;
        r_entry_count <= n_entry_count;
        r_last        <= n_last;
    end

`ifndef ASSERT_OFF
    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("stored count exceeds capacity");

    a_list_counter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST) == (r_left != '0))
        else $error("list counter out of step with state");

    a_no_accept_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST) |-> !i_req.ready)
        else $error("request taken while listing");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req.operation == sus_pkg::OP_INSERT && !w_found && !w_full)
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the set");
`endif

endmodule
